[rtl/bmsi_pkg.sv]
package bmsi_pkg;

	localparam int CFG_INDEX_W = 2;

	typedef enum logic [2:0] {
		CMD_WRITE     = 3'd0,
		CMD_TICK      = 3'd1,
		CMD_A12       = 3'd2,
		CMD_PRG_QUERY = 3'd3,
		CMD_CHR_QUERY = 3'd4
	} cmd_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BOARD_VARIANT = 2'd0,
		CFG_PRG_BANK_MAX  = 2'd1,
		CFG_CHR_BANK_MAX  = 2'd2
	} cfg_index_t;

	// CPU register decode
	localparam logic [15:0] REG_DECODE_MASK = 16'hF001;
	localparam logic [15:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [15:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [15:0] REG_MIRRORING   = 16'hA000;
	localparam logic [15:0] REG_IRQ_LATCH   = 16'hC000;
	localparam logic [15:0] REG_IRQ_RELOAD  = 16'hC001;
	localparam logic [15:0] REG_IRQ_ACK     = 16'hE000;
	localparam logic [15:0] REG_IRQ_ENABLE  = 16'hE001;

	// bit positions inside the bank select byte
	localparam int SEL_CHR_1K_BIT     = 5;
	localparam int SEL_PRG_MODE_BIT   = 6;
	localparam int SEL_CHR_INVERT_BIT = 7;

	// bank data register indexes
	localparam logic [3:0] RI_CHR_2K0  = 4'd0;
	localparam logic [3:0] RI_CHR_2K1  = 4'd1;
	localparam logic [3:0] RI_CHR_1K0  = 4'd2;
	localparam logic [3:0] RI_CHR_1K1  = 4'd3;
	localparam logic [3:0] RI_CHR_1K2  = 4'd4;
	localparam logic [3:0] RI_CHR_1K3  = 4'd5;
	localparam logic [3:0] RI_PRG0     = 4'd6;
	localparam logic [3:0] RI_PRG1     = 4'd7;
	localparam logic [3:0] RI_CHR_EXT0 = 4'd8;
	localparam logic [3:0] RI_CHR_EXT1 = 4'd9;
	localparam logic [3:0] RI_PRG2     = 4'd15;

	localparam logic [1:0] PRG_SLOT_FIXED = 2'd3;

	localparam logic [7:0] PRG_MAX_RESET = 8'd63;
	localparam logic [7:0] CHR_MAX_RESET = 8'd255;

	localparam logic [1:0] IRQ_DELAY_A12 = 2'd3;
	localparam logic [1:0] IRQ_DELAY_CPU = 2'd3;
	localparam logic [1:0] PRESCALE_LAST = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] addr;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic       board_variant;
		logic [7:0] prg_bank_max;
		logic [7:0] chr_bank_max;
	} cfg_t;

endpackage

[rtl/bmsi_if.sv]
interface bmsi_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [15:0] addr;
	logic [7:0]  data;

	modport source (output valid, output cmd, output addr, output data, input ready);
	modport sink (input valid, input cmd, input addr, input data, output ready);
endinterface

interface bmsi_rsp_if;
	logic       valid;
	logic       ready;
	logic       irq;
	logic [7:0] bank;
	logic       nametable_page;

	modport source (output valid, output irq, output bank, output nametable_page, input ready);
	modport sink (input valid, input irq, input bank, input nametable_page, output ready);
endinterface

[rtl/bmsi_bank.sv]
module bmsi_bank (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  bmsi_pkg::item_t item,
	input  bmsi_pkg::cfg_t  cfg,
	output logic [7:0]     bank,
	output logic           nametable_page
);
	import bmsi_pkg::*;

	logic [3:0] reg_index_q;
	logic       prg_mode_q;
	logic [1:0] chr_mode_q;
	logic [7:0] chr_bank_q [8];
	logic [7:0] prg_bank_q [3];
	logic       mirror_h_q;
	logic [3:0] nt_page_q;

	logic [15:0] reg_addr;
	logic        wr;
	logic        page_bit;

	assign reg_addr = item.addr & REG_DECODE_MASK;
	assign wr       = fire && (item.cmd == CMD_WRITE);
	assign page_bit = ~item.data[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_index_q <= '0;
			prg_mode_q  <= 1'b0;
			chr_mode_q  <= '0;
			for (int i = 0; i < 8; i++) chr_bank_q[i] <= 8'(i);
			for (int i = 0; i < 3; i++) prg_bank_q[i] <= 8'(i);
			mirror_h_q  <= 1'b0;
			nt_page_q   <= '0;
		end else if (wr) begin
			case (reg_addr)
				REG_BANK_SELECT: begin
					reg_index_q <= item.data[3:0];
					prg_mode_q  <= item.data[SEL_PRG_MODE_BIT];
					chr_mode_q  <= {item.data[SEL_CHR_INVERT_BIT], item.data[SEL_CHR_1K_BIT]};
				end
				REG_BANK_DATA: begin
					case (reg_index_q) inside
						RI_CHR_2K0, RI_CHR_2K1: begin
							// 2 KB registers carry the page for two nametable slots
							if (cfg.board_variant && !chr_mode_q[1]) begin
								nt_page_q[{reg_index_q[0], 1'b0}] <= page_bit;
								nt_page_q[{reg_index_q[0], 1'b1}] <= page_bit;
							end
							chr_bank_q[reg_index_q[2:0]] <= item.data;
						end
						RI_CHR_1K0, RI_CHR_1K1, RI_CHR_1K2, RI_CHR_1K3: begin
							if (cfg.board_variant && chr_mode_q[1])
								nt_page_q[2'(reg_index_q - 4'd2)] <= page_bit;
							chr_bank_q[reg_index_q[2:0]] <= item.data & cfg.chr_bank_max;
						end
						RI_PRG0, RI_PRG1: begin
							prg_bank_q[{1'b0, reg_index_q[0]}] <= item.data & cfg.prg_bank_max;
						end
						RI_CHR_EXT0, RI_CHR_EXT1: begin
							chr_bank_q[3'(reg_index_q - 4'd2)] <= item.data & cfg.chr_bank_max;
						end
						RI_PRG2: begin
							prg_bank_q[2] <= item.data & cfg.prg_bank_max;
						end
						default: ;
					endcase
				end
				REG_MIRRORING: begin
					if (!cfg.board_variant) mirror_h_q <= item.data[0];
				end
				default: ;
			endcase
		end
	end

	logic [2:0] chr_slot;
	logic [2:0] chr_idx;
	logic [7:0] chr_raw;
	logic [7:0] chr_bank;
	logic [1:0] prg_slot;
	logic [1:0] prg_idx;
	logic [7:0] prg_bank;
	logic [1:0] nt_slot;
	logic       nt_page;

	always_comb begin
		// character slots: upper half swaps with lower half when inverted
		chr_slot = item.addr[12:10] ^ {chr_mode_q[1], 2'b00};
		if (chr_slot[2]) begin
			chr_idx = 3'(chr_slot - 3'd2);
		end else if (chr_mode_q[0]) begin
			chr_idx = {chr_slot[0], chr_slot[0], chr_slot[1]};
		end else begin
			chr_idx = {2'b00, chr_slot[1]};
		end
		chr_raw = chr_bank_q[chr_idx];
		if (chr_slot[2] || chr_mode_q[0]) begin
			chr_bank = chr_raw & cfg.chr_bank_max;
		end else begin
			chr_bank = {chr_raw[7:1] & cfg.chr_bank_max[7:1], chr_slot[0]};
		end

		prg_slot = item.addr[14:13];
		if (prg_mode_q) begin
			prg_idx = (prg_slot == 2'd0) ? 2'd2 : 2'(prg_slot - 2'd1);
		end else begin
			prg_idx = prg_slot;
		end
		if (prg_slot == PRG_SLOT_FIXED) begin
			prg_bank = cfg.prg_bank_max;
		end else begin
			prg_bank = prg_bank_q[prg_idx] & cfg.prg_bank_max;
		end

		nt_slot = item.addr[11:10];
		if (cfg.board_variant) begin
			nt_page = nt_page_q[nt_slot];
		end else if (mirror_h_q) begin
			nt_page = nt_slot[1];
		end else begin
			nt_page = nt_slot[0];
		end

		bank           = '0;
		nametable_page = 1'b0;
		case (item.cmd)
			CMD_PRG_QUERY: begin
				if (item.addr[15]) bank = prg_bank;
			end
			CMD_CHR_QUERY: begin
				// below 0x2000 pattern space, then nametables up to the palette
				if (!item.addr[13]) begin
					bank = chr_bank;
				end else if (item.addr[13:8] != 6'h3F) begin
					nametable_page = nt_page;
				end
			end
			default: ;
		endcase
	end

	a_variant_keeps_mirror: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_WRITE && cfg.board_variant |=> $stable(mirror_h_q))
		else $error("mirroring changed on a paged board");

endmodule

[rtl/bmsi_irq.sv]
module bmsi_irq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  bmsi_pkg::item_t item,
	output logic           irq_next
);
	import bmsi_pkg::*;

	logic       mode_cpu_q, mode_cpu_d;
	logic [1:0] presc_q, presc_d;
	logic [1:0] delay_q, delay_d;
	logic [7:0] latch_q, latch_d;
	logic [7:0] counter_q, counter_d;
	logic       reload_q, reload_d;
	logic       enabled_q, enabled_d;
	logic       prev_nz_q, prev_nz_d;
	logic       line_q, line_d;

	logic [15:0] reg_addr;

	assign reg_addr = item.addr & REG_DECODE_MASK;

	always_comb begin
		mode_cpu_d = mode_cpu_q;
		presc_d    = presc_q;
		delay_d    = delay_q;
		latch_d    = latch_q;
		counter_d  = counter_q;
		reload_d   = reload_q;
		enabled_d  = enabled_q;
		prev_nz_d  = prev_nz_q;
		line_d     = line_q;
		if (fire) begin
			case (item.cmd)
				CMD_WRITE: begin
					case (reg_addr)
						REG_IRQ_LATCH: latch_d = item.data;
						REG_IRQ_RELOAD: begin
							reload_d = 1'b1;
							if (item.data[0]) begin
								mode_cpu_d = 1'b1;
								presc_d    = '0;
							end else begin
								mode_cpu_d = 1'b0;
								counter_d  = '0;
							end
						end
						REG_IRQ_ACK: begin
							enabled_d = 1'b0;
							line_d    = 1'b0;
						end
						REG_IRQ_ENABLE: enabled_d = 1'b1;
						default: ;
					endcase
				end
				CMD_A12: begin
					if (!mode_cpu_q) begin
						if (counter_q == 8'd0) begin
							counter_d = latch_q;
							if (reload_q) begin
								counter_d = 8'(latch_q + 8'd1);
								prev_nz_d = 1'b0;
							end
							// a pending reload that lands on zero still fires
							if (counter_d == 8'd0 && reload_q) prev_nz_d = 1'b1;
							reload_d = 1'b0;
						end else begin
							counter_d = 8'(counter_q - 8'd1);
						end
						if (counter_d == 8'd0 && prev_nz_d && enabled_q) delay_d = IRQ_DELAY_A12;
						prev_nz_d = (counter_d != 8'd0);
					end
				end
				CMD_TICK: begin
					if (delay_q != 2'd0) begin
						delay_d = 2'(delay_q - 2'd1);
						if (delay_d == 2'd0) line_d = 1'b1;
					end
					if (mode_cpu_q) begin
						if (presc_q != PRESCALE_LAST) begin
							presc_d = 2'(presc_q + 2'd1);
						end else begin
							presc_d = '0;
							if (reload_q) begin
								counter_d = 8'(latch_q + 8'd1);
								reload_d  = 1'b0;
							end else if (counter_q != 8'd0) begin
								counter_d = 8'(counter_q - 8'd1);
								if (counter_d == 8'd0 && enabled_q) delay_d = IRQ_DELAY_CPU;
							end else begin
								counter_d = latch_q;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_cpu_q <= 1'b1;
			presc_q    <= '0;
			delay_q    <= '0;
			latch_q    <= '0;
			counter_q  <= '0;
			reload_q   <= 1'b0;
			enabled_q  <= 1'b0;
			prev_nz_q  <= 1'b0;
			line_q     <= 1'b0;
		end else begin
			mode_cpu_q <= mode_cpu_d;
			presc_q    <= presc_d;
			delay_q    <= delay_d;
			latch_q    <= latch_d;
			counter_q  <= counter_d;
			reload_q   <= reload_d;
			enabled_q  <= enabled_d;
			prev_nz_q  <= prev_nz_d;
			line_q     <= line_d;
		end
	end

	assign irq_next = line_d;

	a_line_rises_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(line_q) |-> $past(fire && item.cmd == CMD_TICK))
		else $error("irq line rose outside a cpu tick");

	a_write_keeps_delay: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_WRITE |=> $stable(delay_q))
		else $error("register write disturbed the irq delay");

	a_a12_ignored_in_cpu_mode: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item.cmd == CMD_A12 && mode_cpu_q |=> $stable(counter_q))
		else $error("A12 edge clocked the counter in cpu mode");

endmodule

[rtl/bank_mapper_with_scanline_irq.sv]
// Channel  Direction  Handshake     Payload
// req      in         valid/ready   cmd[2:0], addr[15:0], data[7:0]
// rsp      out        valid/ready   irq, bank[7:0], nametable_page
// cfg      in         cfg_we        cfg_index[1:0], cfg_wdata[7:0]
//
// One request per cycle while the rsp register is not stalled; each result is registered in the rsp register.
// The request register feeds the bank and IRQ logic, whose result lands in the rsp register.
// A full rsp register without rsp.ready stalls the request register, which, if it holds a request, drops req.ready.
// arst_n resets all control and mapping state at once, to defaults rather than all zero; no clearing pass.
module bank_mapper_with_scanline_irq (
	input  logic                              clk,
	input  logic                              arst_n,
	bmsi_req_if.sink                          req,
	bmsi_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [bmsi_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [7:0]                        cfg_wdata
);
	import bmsi_pkg::*;

	cfg_t  cfg_q;
	item_t item_s1;
	logic  valid_s1;
	logic  advance;
	logic  fire_s1;

	logic       rsp_valid_q;
	logic       rsp_irq_q;
	logic [7:0] rsp_bank_q;
	logic       rsp_page_q;

	logic       irq_next;
	logic [7:0] bank;
	logic       nametable_page;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.board_variant <= 1'b0;
			cfg_q.prg_bank_max  <= PRG_MAX_RESET;
			cfg_q.chr_bank_max  <= CHR_MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BOARD_VARIANT: cfg_q.board_variant <= cfg_wdata[0];
				CFG_PRG_BANK_MAX:  cfg_q.prg_bank_max  <= cfg_wdata;
				CFG_CHR_BANK_MAX:  cfg_q.chr_bank_max  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= '{cmd: req.cmd, addr: req.addr, data: req.data};
		end
	end

	bmsi_bank u_bank (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire_s1),
		.item           (item_s1),
		.cfg            (cfg_q),
		.bank           (bank),
		.nametable_page (nametable_page)
	);

	bmsi_irq u_irq (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire_s1),
		.item     (item_s1),
		.irq_next (irq_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_irq_q  <= irq_next;
			rsp_bank_q <= bank;
			rsp_page_q <= nametable_page;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.irq            = rsp_irq_q;
	assign rsp.bank           = rsp_bank_q;
	assign rsp.nametable_page = rsp_page_q;

	a_fire_fills_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> rsp_valid_q)
		else $error("request left stage one without a result");

	a_non_query_zero_bank: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.cmd != CMD_PRG_QUERY && item_s1.cmd != CMD_CHR_QUERY
		|=> rsp_bank_q == 8'd0 && !rsp_page_q)
		else $error("non-query request produced a bank or page");

endmodule
